/* design/qte_pkg.sv */
// shared constants and the arctangent table for the quaternion to euler core
`default_nettype none
package qte_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 14;
   localparam int TAB_LEN          = 24;
   localparam int ANG_W            = 28;
   localparam int PROD_FRAC        = 28;
   localparam int ANG_SHIFT        = 11;
   localparam int MAX_ANG_OUT      = 25736;
   localparam int MAX_PITCH_OUT    = 12868;
   localparam logic signed [ANG_W-1:0] HALF_PI_ANG = 28'sd26353589;

   // atan(2^-i) in radians * 2^24
   function automatic logic signed [ANG_W-1:0] atan_tab(input int idx);
      logic signed [ANG_W-1:0] v;
      unique case (idx)
         0:  v = 28'sd13176795;
         1:  v = 28'sd7778716;
         2:  v = 28'sd4110060;
         3:  v = 28'sd2086331;
         4:  v = 28'sd1047214;
         5:  v = 28'sd524117;
         6:  v = 28'sd262123;
         7:  v = 28'sd131069;
         8:  v = 28'sd65536;
         9:  v = 28'sd32768;
         10: v = 28'sd16384;
         11: v = 28'sd8192;
         12: v = 28'sd4096;
         13: v = 28'sd2048;
         14: v = 28'sd1024;
         15: v = 28'sd512;
         16: v = 28'sd256;
         17: v = 28'sd128;
         18: v = 28'sd64;
         19: v = 28'sd32;
         20: v = 28'sd16;
         21: v = 28'sd8;
         22: v = 28'sd4;
         23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* design/qte_cordic.sv */
// pipelined vectoring cordic atan2 with rounding and saturation of the angle
`default_nettype none
module qte_cordic import qte_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF,
   parameter int IN_W  = FRAC_BITS_DEF + 7,
   parameter int LIM   = MAX_ANG_OUT,
   parameter int OUT_W = 16
) (
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic signed [IN_W-1:0]  in_y,
   input  wire logic signed [IN_W-1:0]  in_x,
   output logic signed [OUT_W-1:0]      ang
);

   localparam int CW = IN_W + 3;

   logic signed [CW-1:0]    x_ff [0:STEPS];
   logic signed [CW-1:0]    y_ff [0:STEPS];
   logic signed [ANG_W-1:0] z_ff [0:STEPS];
   logic                    zero_ff [0:STEPS];
   logic signed [OUT_W-1:0] ang_ff;

   logic signed [CW-1:0]    x0_in, y0_in, xe, ye;
   logic signed [ANG_W-1:0] z0_in;

   // turn left half plane vectors into the right half plane
   always_comb begin
      xe = CW'(in_x);
      ye = CW'(in_y);
      x0_in = xe;
      y0_in = ye;
      z0_in = '0;
      if (xe < 0) begin
         if (ye >= 0) begin
            x0_in = ye;
            y0_in = -xe;
            z0_in = HALF_PI_ANG;
         end else begin
            x0_in = -ye;
            y0_in = xe;
            z0_in = -HALF_PI_ANG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [CW-1:0]    x_in, y_in;
      logic signed [ANG_W-1:0] z_in;
      always_comb begin
         if (y_ff[i] >= 0) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + atan_tab(i);
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - atan_tab(i);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   logic signed [ANG_W-1:0] r;
   logic signed [OUT_W-1:0] ang_in;
   localparam logic signed [ANG_W-1:0] LIM_V = ANG_W'(LIM);
   localparam logic signed [ANG_W-1:0] HALF_LSB = ANG_W'(1 << (ANG_SHIFT - 1));

   always_comb begin
      r = (z_ff[STEPS] + HALF_LSB) >>> ANG_SHIFT;
      if (zero_ff[STEPS])   ang_in = '0;
      else if (r > LIM_V)   ang_in = OUT_W'(LIM_V);
      else if (r < -LIM_V)  ang_in = OUT_W'(-LIM_V);
      else                  ang_in = OUT_W'(r);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= ang_in;
      end
   end

   assign ang = ang_ff;

endmodule
`default_nettype wire

/* design/quaternion_to_euler_core.sv */
// quaternion to roll, pitch and yaw euler angles, fully pipelined
`default_nettype none
// Takes one Q2.14 quaternion per cycle and returns roll, pitch and yaw in
// radians * 8192, plus a flag when the pitch sine term left the unit range.
// Every stage is registered and one transfer can enter each clock unless the
// pipeline is stalled; the latency is set by the products and terms, the
// bit-per-stage square root for the pitch cosine and the one-rotation-per-stage
// cordic.
// A stall on rsp freezes the whole pipeline, so req_stall follows rsp_stall
// whenever a result is waiting.
module quaternion_to_euler_core import qte_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic signed [15:0] req_quat_w,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_roll_angle,
   output logic signed [14:0]      rsp_pitch_angle,
   output logic signed [15:0]      rsp_yaw_angle,
   output logic                    rsp_pitch_clamped
);

   localparam int SH  = PROD_FRAC - FRAC_BITS;    // rounding shift of the terms
   localparam int TW  = FRAC_BITS + 7;            // rounded term width
   localparam int SQW = 2 * FRAC_BITS + 1;        // square root operand width
   localparam int NSQ = FRAC_BITS + 1;            // square root stages
   localparam int NCS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
   localparam int LAT = 4 + NSQ + NCS + 2;

   localparam logic signed [35:0] ONE = 36'sd268435456;
   localparam logic signed [35:0] HALF_T = 36'(1 << (SH - 1));
   localparam logic [2*TW-1:0] ONE2 = (2*TW)'(1) << (2 * FRAC_BITS);

   // pipeline advances unless a finished result is held back
   logic en;
   assign req_stall = rsp_valid & rsp_stall;
   assign en = ~req_stall;

   // valid bits travel alongside the data
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end
   assign rsp_valid = vld_ff[LAT-1];

   // stage 1: products of the components
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= 32'(req_quat_w) * 32'(req_quat_x);
         yz_ff <= 32'(req_quat_y) * 32'(req_quat_z);
         xx_ff <= 32'(req_quat_x) * 32'(req_quat_x);
         yy_ff <= 32'(req_quat_y) * 32'(req_quat_y);
         wy_ff <= 32'(req_quat_w) * 32'(req_quat_y);
         zx_ff <= 32'(req_quat_z) * 32'(req_quat_x);
         wz_ff <= 32'(req_quat_w) * 32'(req_quat_z);
         xy_ff <= 32'(req_quat_x) * 32'(req_quat_y);
         zz_ff <= 32'(req_quat_z) * 32'(req_quat_z);
      end
   end

   // stage 2: exact terms with 28 fraction bits, pitch term clamped
   logic signed [35:0] t0_ff, t1_ff, t2_ff, t3_ff, t4_ff;
   logic               clamp_ff;
   logic signed [35:0] t2_raw, t2_in;
   logic               clamp_in;

   always_comb begin
      t2_raw = (36'(wy_ff) - 36'(zx_ff)) <<< 1;
      clamp_in = 1'b0;
      t2_in = t2_raw;
      if (t2_raw > ONE) begin
         t2_in = ONE;
         clamp_in = 1'b1;
      end else if (t2_raw < -ONE) begin
         t2_in = -ONE;
         clamp_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff    <= (36'(wx_ff) + 36'(yz_ff)) <<< 1;
         t1_ff    <= ONE - ((36'(xx_ff) + 36'(yy_ff)) <<< 1);
         t2_ff    <= t2_in;
         t3_ff    <= (36'(wz_ff) + 36'(xy_ff)) <<< 1;
         t4_ff    <= ONE - ((36'(yy_ff) + 36'(zz_ff)) <<< 1);
         clamp_ff <= clamp_in;
      end
   end

   // stage 3: round half up to FRAC_BITS fraction bits
   function automatic logic signed [TW-1:0] rnd(input logic signed [35:0] v);
      logic signed [35:0] s;
      s = (v + HALF_T) >>> SH;
      return TW'(s);
   endfunction

   logic signed [TW-1:0] ry_ff, rx_ff, yy3_ff, yx_ff, s_ff;
   logic                 clamp3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ry_ff     <= rnd(t0_ff);
         rx_ff     <= rnd(t1_ff);
         s_ff      <= rnd(t2_ff);
         yy3_ff    <= rnd(t3_ff);
         yx_ff     <= rnd(t4_ff);
         clamp3_ff <= clamp_ff;
      end
   end

   // stage 4 onward: 1 - s^2, then one square root bit per stage
   logic [SQW-1:0]       sq_rem_ff [0:NSQ];
   logic [SQW-1:0]       sq_res_ff [0:NSQ];
   logic signed [TW-1:0] d_ry_ff [0:NSQ];
   logic signed [TW-1:0] d_rx_ff [0:NSQ];
   logic signed [TW-1:0] d_yy_ff [0:NSQ];
   logic signed [TW-1:0] d_yx_ff [0:NSQ];
   logic signed [TW-1:0] d_s_ff  [0:NSQ];
   logic                 d_cl_ff [0:NSQ];

   logic signed [2*TW-1:0] ssq;
   assign ssq = (2*TW)'(s_ff) * (2*TW)'(s_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_rem_ff[0] <= SQW'($signed(ONE2) - ssq);
         sq_res_ff[0] <= '0;
         d_ry_ff[0]   <= ry_ff;
         d_rx_ff[0]   <= rx_ff;
         d_yy_ff[0]   <= yy3_ff;
         d_yx_ff[0]   <= yx_ff;
         d_s_ff[0]    <= s_ff;
         d_cl_ff[0]   <= clamp3_ff;
      end
   end

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      localparam logic [SQW:0] BIT = (SQW+1)'(1) << (2 * (FRAC_BITS - k));
      logic [SQW:0]   trial;
      logic [SQW-1:0] rem_in, res_in;
      always_comb begin
         trial = (SQW+1)'(sq_res_ff[k]) + BIT;
         if ((SQW+1)'(sq_rem_ff[k]) >= trial) begin
            rem_in = SQW'((SQW+1)'(sq_rem_ff[k]) - trial);
            res_in = SQW'((SQW+1)'(sq_res_ff[k] >> 1) + BIT);
         end else begin
            rem_in = sq_rem_ff[k];
            res_in = sq_res_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k+1] <= rem_in;
            sq_res_ff[k+1] <= res_in;
            d_ry_ff[k+1]   <= d_ry_ff[k];
            d_rx_ff[k+1]   <= d_rx_ff[k];
            d_yy_ff[k+1]   <= d_yy_ff[k];
            d_yx_ff[k+1]   <= d_yx_ff[k];
            d_s_ff[k+1]    <= d_s_ff[k];
            d_cl_ff[k+1]   <= d_cl_ff[k];
         end
      end
   end

   logic signed [TW-1:0] cos_t;
   assign cos_t = TW'(sq_res_ff[NSQ]);

   // three cordic pipelines in lockstep
   qte_cordic #(.STEPS(NCS), .IN_W(TW), .LIM(MAX_ANG_OUT), .OUT_W(16)) u_roll (
      .clock (clock),
      .en    (en),
      .in_y  (d_ry_ff[NSQ]),
      .in_x  (d_rx_ff[NSQ]),
      .ang   (rsp_roll_angle)
   );

   qte_cordic #(.STEPS(NCS), .IN_W(TW), .LIM(MAX_PITCH_OUT), .OUT_W(15)) u_pitch (
      .clock (clock),
      .en    (en),
      .in_y  (d_s_ff[NSQ]),
      .in_x  (cos_t),
      .ang   (rsp_pitch_angle)
   );

   qte_cordic #(.STEPS(NCS), .IN_W(TW), .LIM(MAX_ANG_OUT), .OUT_W(16)) u_yaw (
      .clock (clock),
      .en    (en),
      .in_y  (d_yy_ff[NSQ]),
      .in_x  (d_yx_ff[NSQ]),
      .ang   (rsp_yaw_angle)
   );

   // clamp flag follows the cordic latency
   logic [NCS+1:0] cl_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         cl_ff <= {cl_ff[NCS:0], d_cl_ff[NSQ]};
      end
   end
   assign rsp_pitch_clamped = cl_ff[NCS+1];

endmodule
`default_nettype wire

/* design/qte_checker.sv */
// port level checks for the quaternion to euler core and their bind
`default_nettype none
module qte_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_roll_angle,
   input wire logic signed [14:0] rsp_pitch_angle,
   input wire logic signed [15:0] rsp_yaw_angle,
   input wire logic               rsp_pitch_clamped
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_roll_angle) && $stable(rsp_pitch_angle)
         && $stable(rsp_yaw_angle) && $stable(rsp_pitch_clamped))
      else $error("rsp payload changed while stalled");

   // input side only backs up behind a waiting result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a held result");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_angle <= 15'sd12868 && rsp_pitch_angle >= -15'sd12868)
      else $error("pitch out of range");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll_angle <= 16'sd25736 && rsp_roll_angle >= -16'sd25736
         && rsp_yaw_angle <= 16'sd25736 && rsp_yaw_angle >= -16'sd25736)
      else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_core qte_checker u_qte_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_roll_angle    (rsp_roll_angle),
   .rsp_pitch_angle   (rsp_pitch_angle),
   .rsp_yaw_angle     (rsp_yaw_angle),
   .rsp_pitch_clamped (rsp_pitch_clamped)
);
`default_nettype wire
